@@ hw/rtl/bmm_pkg.sv @@
`timescale 1ns / 1ps

package bmm_pkg;

  localparam int MAX_MASKS   = 8;
  localparam int QUEUE_DEPTH = 256;
  localparam int VALUE_WIDTH = 32;

  localparam int STORE_DEPTH = MAX_MASKS * QUEUE_DEPTH;
  localparam int QIDX_W      = 3;
  localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W      = QIDX_W + QADDR_W;
  // counts reach one above QUEUE_DEPTH on an exhausted read
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 2);
  localparam int CFG_W       = 4;
  localparam int OP_W        = 2;
  localparam int STAT_W      = 3;
  localparam int BITS_W      = 8;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_POS    = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NO_MASK   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 3'd2;
  localparam logic [STAT_W-1:0] STAT_MISMATCH  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_LOAD_REJ  = 3'd4;

  localparam logic [CFG_W-1:0] MASKS_RESET = 4'd8;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic accept;
    logic fill_read;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;
    logic read_hit;
  } dp_status_t;

endpackage

@@ hw/rtl/bmm_in_if.sv @@
`timescale 1ns / 1ps

interface bmm_in_if;
  logic                             valid;
  logic                             ready;
  logic [bmm_pkg::OP_W-1:0]         op;
  logic [bmm_pkg::QIDX_W-1:0]       queue_index;
  logic [bmm_pkg::VALUE_WIDTH-1:0]  load_value;
  logic [bmm_pkg::BITS_W-1:0]       mask_bits;

  modport source (output valid, op, queue_index, load_value, mask_bits, input ready);
  modport sink   (input valid, op, queue_index, load_value, mask_bits, output ready);
endinterface

@@ hw/rtl/bmm_out_if.sv @@
`timescale 1ns / 1ps

interface bmm_out_if;
  logic                             valid;
  logic                             ready;
  logic [bmm_pkg::STAT_W-1:0]       status;
  logic [bmm_pkg::VALUE_WIDTH-1:0]  out_value;
  logic [bmm_pkg::QIDX_W-1:0]       chosen_mask;
  logic                             value_valid;

  modport source (output valid, status, out_value, chosen_mask, value_valid, input ready);
  modport sink   (input valid, status, out_value, chosen_mask, value_valid, output ready);
endinterface

@@ hw/rtl/bmm_ctrl.sv @@
`timescale 1ns / 1ps

module bmm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_ready,
  input  bmm_pkg::dp_status_t dp_stat,
  output logic                in_ready,
  output bmm_pkg::ctrl_cmd_t  cmd
);

  bmm_pkg::state_t state;
  bmm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bmm_pkg::ST_IDLE: begin
        if (in_valid && in_ready && dp_stat.read_hit) begin
          state_next = bmm_pkg::ST_READ;
        end
      end
      bmm_pkg::ST_READ: begin
        state_next = bmm_pkg::ST_IDLE;
      end
      default: begin
        state_next = bmm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.fill_read = 1'b0;
    case (state)
      bmm_pkg::ST_IDLE: begin
        // take an item once the result slot is free by the next edge
        in_ready   = !dp_stat.out_full || out_ready;
        cmd.accept = in_valid && in_ready;
      end
      bmm_pkg::ST_READ: begin
        cmd.fill_read = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ hw/rtl/bmm_datapath.sv @@
`timescale 1ns / 1ps

module bmm_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bmm_pkg::CFG_W-1:0]          cfg_data,
  input  bmm_pkg::ctrl_cmd_t                 cmd,
  input  logic [bmm_pkg::OP_W-1:0]           op,
  input  logic [bmm_pkg::QIDX_W-1:0]         queue_index,
  input  logic [bmm_pkg::VALUE_WIDTH-1:0]    load_value,
  input  logic [bmm_pkg::BITS_W-1:0]         mask_bits,
  input  logic                               out_ready,
  output bmm_pkg::dp_status_t                dp_stat,
  output logic                               out_valid,
  output logic [bmm_pkg::STAT_W-1:0]         status,
  output logic [bmm_pkg::VALUE_WIDTH-1:0]    out_value,
  output logic [bmm_pkg::QIDX_W-1:0]         chosen_mask,
  output logic                               value_valid
);

  logic [bmm_pkg::VALUE_WIDTH-1:0] value_store [bmm_pkg::STORE_DEPTH];
  logic [bmm_pkg::VALUE_WIDTH-1:0] rd_data;

  logic [bmm_pkg::CNT_W-1:0] loaded_count   [bmm_pkg::MAX_MASKS];
  logic [bmm_pkg::CNT_W-1:0] consumed_count [bmm_pkg::MAX_MASKS];

  logic [bmm_pkg::CFG_W-1:0]     masks_in_use;
  logic [bmm_pkg::CFG_W-1:0]     n_act;
  logic [bmm_pkg::MAX_MASKS-1:0] active;
  logic [bmm_pkg::MAX_MASKS-1:0] sel_bits;
  logic [bmm_pkg::MAX_MASKS-1:0] mismatch;
  logic                          pos_any;
  logic [bmm_pkg::QIDX_W-1:0]    pos_idx;
  logic                          fin_any;
  logic [bmm_pkg::QIDX_W-1:0]    fin_idx;
  logic                          load_ok;
  logic                          hit;
  logic [bmm_pkg::QIDX_W-1:0]    pend_chosen;
  logic [bmm_pkg::CNT_W-1:0]     pos_cons;
  logic [bmm_pkg::CNT_W-1:0]     pos_load;

  logic [bmm_pkg::STAT_W-1:0]    dir_status;
  logic [bmm_pkg::QIDX_W-1:0]    dir_chosen;

  always_ff @(posedge clk) begin
    if (rst) begin
      masks_in_use <= bmm_pkg::MASKS_RESET;
    end else if (cfg_we) begin
      masks_in_use <= cfg_data;
    end
  end

  always_comb begin
    n_act = (masks_in_use > bmm_pkg::CFG_W'(bmm_pkg::MAX_MASKS))
          ? bmm_pkg::CFG_W'(bmm_pkg::MAX_MASKS) : masks_in_use;
    for (int j = 0; j < bmm_pkg::MAX_MASKS; j++) begin
      active[j]   = bmm_pkg::CFG_W'(j) < n_act;
      mismatch[j] = active[j] && (consumed_count[j] != loaded_count[j]);
    end
    sel_bits = mask_bits & active;
  end

  // lowest set bit wins: scan from the top down
  always_comb begin
    pos_any = 1'b0;
    pos_idx = '0;
    fin_any = 1'b0;
    fin_idx = '0;
    for (int j = bmm_pkg::MAX_MASKS - 1; j >= 0; j--) begin
      if (sel_bits[j]) begin
        pos_any = 1'b1;
        pos_idx = bmm_pkg::QIDX_W'(j);
      end
      if (mismatch[j]) begin
        fin_any = 1'b1;
        fin_idx = bmm_pkg::QIDX_W'(j);
      end
    end
  end

  always_comb begin
    pos_cons = consumed_count[pos_idx];
    pos_load = loaded_count[pos_idx];
    load_ok  = active[queue_index]
            && (loaded_count[queue_index] < bmm_pkg::CNT_W'(bmm_pkg::QUEUE_DEPTH));
    hit      = (op == bmm_pkg::OP_POS) && pos_any && (pos_cons < pos_load);
    dp_stat.read_hit = hit;
    dp_stat.out_full = out_valid;
  end

  always_comb begin
    dir_status = bmm_pkg::STAT_OK;
    dir_chosen = '0;
    case (op)
      bmm_pkg::OP_LOAD: begin
        dir_status = load_ok ? bmm_pkg::STAT_OK : bmm_pkg::STAT_LOAD_REJ;
      end
      bmm_pkg::OP_POS: begin
        dir_status = pos_any ? bmm_pkg::STAT_EXHAUSTED : bmm_pkg::STAT_NO_MASK;
        dir_chosen = pos_idx;
      end
      bmm_pkg::OP_FINISH: begin
        dir_status = fin_any ? bmm_pkg::STAT_MISMATCH : bmm_pkg::STAT_OK;
        dir_chosen = fin_idx;
      end
      default: begin
        dir_status = bmm_pkg::STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (op == bmm_pkg::OP_LOAD) && load_ok) begin
      value_store[{queue_index, loaded_count[queue_index][bmm_pkg::QADDR_W-1:0]}]
        <= load_value;
    end
    if (cmd.accept && hit) begin
      rd_data <= value_store[{pos_idx, pos_cons[bmm_pkg::QADDR_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < bmm_pkg::MAX_MASKS; j++) begin
        loaded_count[j]   <= '0;
        consumed_count[j] <= '0;
      end
    end else if (cmd.accept) begin
      case (op)
        bmm_pkg::OP_LOAD: begin
          if (load_ok) begin
            loaded_count[queue_index] <= loaded_count[queue_index] + 1'b1;
          end
        end
        bmm_pkg::OP_POS: begin
          // an exhausted queue goes one past its load count, never further
          if (pos_any && (pos_cons <= pos_load)) begin
            consumed_count[pos_idx] <= pos_cons + 1'b1;
          end
        end
        bmm_pkg::OP_FINISH: begin
          for (int j = 0; j < bmm_pkg::MAX_MASKS; j++) begin
            loaded_count[j]   <= '0;
            consumed_count[j] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.accept && !hit) || cmd.fill_read) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && hit) begin
      pend_chosen <= pos_idx;
    end
    if (cmd.fill_read) begin
      status      <= bmm_pkg::STAT_OK;
      out_value   <= rd_data;
      chosen_mask <= pend_chosen;
      value_valid <= 1'b1;
    end else if (cmd.accept && !hit) begin
      status      <= dir_status;
      out_value   <= '0;
      chosen_mask <= dir_chosen;
      value_valid <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/boolean_mask_merge_core.sv @@
`timescale 1ns / 1ps
// Timing: a load, finish, unused or non-reading position item gives its result in the cycle
// after its transfer; a position item that reads a value registers the store read, then the result.
// Throughput: one item per cycle while the receiver keeps up, but a position item that reads
// a value holds off the next item until the registered read of the single value store port is done.
// Reset: counts cleared, masks_in_use set to 8; value store contents undefined, no clear pass.

module boolean_mask_merge_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bmm_pkg::CFG_W-1:0]   cfg_data,
  bmm_in_if.sink                      in_ch,
  bmm_out_if.source                   out_ch
);

  bmm_pkg::ctrl_cmd_t  cmd;
  bmm_pkg::dp_status_t dp_stat;

  bmm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .dp_stat   (dp_stat),
    .in_ready  (in_ch.ready),
    .cmd       (cmd)
  );

  bmm_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .op          (in_ch.op),
    .queue_index (in_ch.queue_index),
    .load_value  (in_ch.load_value),
    .mask_bits   (in_ch.mask_bits),
    .out_ready   (out_ch.ready),
    .dp_stat     (dp_stat),
    .out_valid   (out_ch.valid),
    .status      (out_ch.status),
    .out_value   (out_ch.out_value),
    .chosen_mask (out_ch.chosen_mask),
    .value_valid (out_ch.value_valid)
  );

endmodule

@@ bench/boolean_mask_merge_core_tb.sv @@
`timescale 1ns / 1ps

module boolean_mask_merge_core_tb;

  localparam logic [bmm_pkg::OP_W-1:0] OP_UNUSED    = 2'd3;
  localparam int                       CYCLE_LIMIT  = 500000;
  localparam int                       RANDOM_ITEMS = 120;
  localparam int                       HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [bmm_pkg::STAT_W-1:0]      status;
    logic [bmm_pkg::VALUE_WIDTH-1:0] out_value;
    logic [bmm_pkg::QIDX_W-1:0]      chosen_mask;
    logic                            value_valid;
  } merge_result_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [bmm_pkg::CFG_W-1:0] cfg_data;

  bmm_in_if  in_ch ();
  bmm_out_if out_ch ();

  boolean_mask_merge_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // shadow of the block's state
  logic [bmm_pkg::VALUE_WIDTH-1:0] queue_store [bmm_pkg::MAX_MASKS][bmm_pkg::QUEUE_DEPTH];
  int                              loaded_cnt [bmm_pkg::MAX_MASKS];
  int                              consumed_cnt [bmm_pkg::MAX_MASKS];
  logic [bmm_pkg::CFG_W-1:0]       masks_cfg;

  merge_result_t merge_results_due [$];
  int            error_count = 0;
  int            result_count = 0;
  int            cycle_count = 0;
  int            hold_left = 0;
  bit            hold_req = 1'b0;
  bit            hold_taken = 1'b0;
  int            stall_left = 0;
  bit            jitter_on = 1'b0;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("boolean_mask_merge_core verification failed");
      $finish;
    end
  end

  // long receiver hold-off, counted down here
  always @(posedge clk)
    if (hold_req && !hold_taken) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(15, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic int active_masks();
    return (masks_cfg > bmm_pkg::MAX_MASKS) ? bmm_pkg::MAX_MASKS : int'(masks_cfg);
  endfunction

  function automatic merge_result_t predict_merge(
      input logic [bmm_pkg::OP_W-1:0] op,
      input logic [bmm_pkg::QIDX_W-1:0] q,
      input logic [bmm_pkg::VALUE_WIDTH-1:0] v,
      input logic [bmm_pkg::BITS_W-1:0] bits);
    merge_result_t r;
    int            n;
    bit            found;
    r.status      = bmm_pkg::STAT_OK;
    r.out_value   = '0;
    r.chosen_mask = '0;
    r.value_valid = 1'b0;
    n             = active_masks();
    found         = 1'b0;
    case (op)
      bmm_pkg::OP_LOAD: begin
        if (q >= n || loaded_cnt[q] >= bmm_pkg::QUEUE_DEPTH) begin
          r.status = bmm_pkg::STAT_LOAD_REJ;
        end else begin
          queue_store[q][loaded_cnt[q]] = v;
          loaded_cnt[q]++;
        end
      end
      bmm_pkg::OP_POS: begin
        r.status = bmm_pkg::STAT_NO_MASK;
        for (int j = 0; j < n; j++) begin
          if (!found && bits[j]) begin
            found         = 1'b1;
            r.chosen_mask = bmm_pkg::QIDX_W'(j);
            if (consumed_cnt[j] < loaded_cnt[j]) begin
              r.out_value   = queue_store[j][consumed_cnt[j]];
              r.value_valid = 1'b1;
              r.status      = bmm_pkg::STAT_OK;
              consumed_cnt[j]++;
            end else begin
              // overshoot by one at most so a later finish sees the mismatch
              if (consumed_cnt[j] == loaded_cnt[j]) consumed_cnt[j]++;
              r.status = bmm_pkg::STAT_EXHAUSTED;
            end
          end
        end
      end
      bmm_pkg::OP_FINISH: begin
        for (int j = 0; j < n; j++) begin
          if (!found && consumed_cnt[j] != loaded_cnt[j]) begin
            found         = 1'b1;
            r.status      = bmm_pkg::STAT_MISMATCH;
            r.chosen_mask = bmm_pkg::QIDX_W'(j);
          end
        end
        for (int j = 0; j < bmm_pkg::MAX_MASKS; j++) begin
          loaded_cnt[j]   = 0;
          consumed_cnt[j] = 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // receiver: random stalls plus the long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) stall_left--;
      else if (jitter_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      out_ch.ready <= !rst && hold_left == 0 && stall_left == 0;
    end
  end

  always @(posedge clk) begin
    merge_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      result_count++;
      if (merge_results_due.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result %0d: status %0d value %h mask %0d valid %b",
                   result_count, out_ch.status, out_ch.out_value, out_ch.chosen_mask,
                   out_ch.value_valid);
      end else begin
        want = merge_results_due.pop_front();
        if (out_ch.status !== want.status || out_ch.out_value !== want.out_value ||
            out_ch.chosen_mask !== want.chosen_mask ||
            out_ch.value_valid !== want.value_valid) begin
          error_count++;
          if (error_count <= 10)
            $display({"result %0d mismatch: expected status %0d value %h mask %0d ",
                      "valid %b, got status %0d value %h mask %0d valid %b"},
                     result_count, want.status, want.out_value, want.chosen_mask,
                     want.value_valid, out_ch.status, out_ch.out_value,
                     out_ch.chosen_mask, out_ch.value_valid);
        end
      end
    end
  end

  // leaves valid high when no gap is taken, so back-to-back sends stream
  task automatic send_item(input logic [bmm_pkg::OP_W-1:0] op,
                           input logic [bmm_pkg::QIDX_W-1:0] q,
                           input logic [bmm_pkg::VALUE_WIDTH-1:0] v,
                           input logic [bmm_pkg::BITS_W-1:0] bits);
    int gap;
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.queue_index <= q;
    in_ch.load_value  <= v;
    in_ch.mask_bits   <= bits;
    do @(posedge clk); while (!in_ch.ready);
    merge_results_due.push_back(predict_merge(op, q, v, bits));
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (merge_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_masks(input logic [bmm_pkg::CFG_W-1:0] count);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
    masks_cfg  = count;
  endtask

  task automatic test_directed();
    jitter_on = 1'b1;
    send_item(bmm_pkg::OP_LOAD, 3'd0, 32'h0000_0000, 8'h00);
    send_item(bmm_pkg::OP_LOAD, 3'd0, 32'hFFFF_FFFF, 8'hFF);
    send_item(bmm_pkg::OP_LOAD, 3'd7, 32'hA5A5_A5A5, 8'h00);
    send_item(bmm_pkg::OP_LOAD, 3'd3, $urandom, 8'h00);
    send_item(bmm_pkg::OP_POS, 3'd0, 32'h0, 8'h00);
    send_item(bmm_pkg::OP_POS, 3'd7, 32'hFFFF_FFFF, 8'h01);
    send_item(bmm_pkg::OP_POS, 3'd0, 32'h0, 8'hFF);
    // queue 0 runs dry, then stays one over its loaded count
    send_item(bmm_pkg::OP_POS, 3'd0, 32'h0, 8'h01);
    send_item(bmm_pkg::OP_POS, 3'd0, 32'h0, 8'h03);
    send_item(bmm_pkg::OP_POS, 3'd0, 32'h0, 8'h80);
    send_item(bmm_pkg::OP_POS, 3'd0, 32'h0, 8'h08);
    send_item(OP_UNUSED, 3'd7, 32'hFFFF_FFFF, 8'hFF);
    send_item(bmm_pkg::OP_FINISH, 3'd0, 32'h0, 8'h00);
    send_item(bmm_pkg::OP_FINISH, 3'd0, 32'h0, 8'h00);
    send_item(bmm_pkg::OP_LOAD, 3'd5, $urandom, 8'h00);
    send_item(bmm_pkg::OP_POS, 3'd0, 32'h0, 8'hE0);
    send_item(bmm_pkg::OP_FINISH, 3'd0, 32'h0, 8'h00);
    wait_idle();
  endtask

  task automatic test_mask_count();
    jitter_on = 1'b1;
    set_masks(4'd3);
    send_item(bmm_pkg::OP_LOAD, 3'd5, $urandom, 8'h00);
    send_item(bmm_pkg::OP_LOAD, 3'd2, $urandom, 8'h00);
    send_item(bmm_pkg::OP_POS, 3'd0, 32'h0, 8'hF8);
    send_item(bmm_pkg::OP_POS, 3'd0, 32'h0, 8'hFC);
    send_item(bmm_pkg::OP_FINISH, 3'd0, 32'h0, 8'h00);
    // unread value in a mask that is switched off must not flag a mismatch
    set_masks(4'd8);
    send_item(bmm_pkg::OP_LOAD, 3'd6, $urandom, 8'h00);
    set_masks(4'd3);
    send_item(bmm_pkg::OP_FINISH, 3'd0, 32'h0, 8'h00);
    set_masks(4'd8);
    send_item(bmm_pkg::OP_FINISH, 3'd0, 32'h0, 8'h00);
    set_masks(4'd0);
    send_item(bmm_pkg::OP_LOAD, 3'd0, $urandom, 8'h00);
    send_item(bmm_pkg::OP_POS, 3'd0, 32'h0, 8'hFF);
    send_item(bmm_pkg::OP_FINISH, 3'd0, 32'h0, 8'h00);
    set_masks(4'd15);
    send_item(bmm_pkg::OP_LOAD, 3'd7, $urandom, 8'h00);
    send_item(bmm_pkg::OP_POS, 3'd0, 32'h0, 8'h80);
    send_item(bmm_pkg::OP_FINISH, 3'd0, 32'h0, 8'h00);
    set_masks(4'd9);
    send_item(bmm_pkg::OP_LOAD, 3'd7, $urandom, 8'h00);
    send_item(bmm_pkg::OP_POS, 3'd0, 32'h0, 8'hC0);
    send_item(bmm_pkg::OP_FINISH, 3'd0, 32'h0, 8'h00);
    set_masks(4'd1);
    send_item(bmm_pkg::OP_LOAD, 3'd1, $urandom, 8'h00);
    send_item(bmm_pkg::OP_LOAD, 3'd0, $urandom, 8'h00);
    send_item(bmm_pkg::OP_POS, 3'd0, 32'h0, 8'hFE);
    send_item(bmm_pkg::OP_POS, 3'd0, 32'h0, 8'h01);
    send_item(bmm_pkg::OP_FINISH, 3'd0, 32'h0, 8'h00);
    set_masks(4'd8);
  endtask

  // fill one queue to the brim, read the first 16 values back and drop the rest at finish
  task automatic test_queue_full();
    jitter_on = 1'b1;
    repeat (bmm_pkg::QUEUE_DEPTH)
      send_item(bmm_pkg::OP_LOAD, 3'd4, $urandom, 8'($urandom_range(0, 255)));
    send_item(bmm_pkg::OP_LOAD, 3'd4, $urandom, 8'h00);
    repeat (16)
      send_item(bmm_pkg::OP_POS, 3'($urandom_range(0, 7)), $urandom,
                8'h10 | (8'($urandom) << 5));
    send_item(bmm_pkg::OP_FINISH, 3'd0, 32'h0, 8'h00);
    send_item(bmm_pkg::OP_FINISH, 3'd0, 32'h0, 8'h00);
    wait_idle();
  endtask

  task automatic test_backpressure();
    int j;
    jitter_on = 1'b0;
    wait_idle();
    hold_req = 1'b1;
    for (int k = 0; k < 60; k++) begin
      j = k % 4;
      if (k < 32) send_item(bmm_pkg::OP_LOAD, 3'(j), $urandom, 8'h00);
      else send_item(bmm_pkg::OP_POS, 3'd0, 32'h0, 8'(1 << j));
    end
    send_item(bmm_pkg::OP_FINISH, 3'd0, 32'h0, 8'h00);
    wait_idle();
  endtask

  task automatic test_random();
    int sent;
    int n;
    int loads_left;
    int j;
    int r;
    int ready_q [$];
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 9);
        if (r == 0) set_masks(4'd0);
        else if (r == 1) set_masks(4'($urandom_range(9, 15)));
        else set_masks(4'($urandom_range(1, 8)));
      end
      jitter_on  = ($urandom_range(0, 4) != 0);
      n          = active_masks();
      loads_left = $urandom_range(1, 12);
      forever begin
        ready_q.delete();
        for (int k = 0; k < n; k++)
          if (consumed_cnt[k] < loaded_cnt[k]) ready_q.push_back(k);
        if (loads_left == 0 && ready_q.size() == 0) break;
        // truncate a few sequences early
        if ($urandom_range(0, 39) == 0) break;
        if ($urandom_range(0, 9) == 0) begin
          send_item(2'($urandom_range(0, 3)), 3'($urandom), $urandom, 8'($urandom));
        end else if (loads_left > 0 && (ready_q.size() == 0 || $urandom_range(0, 1) == 0)) begin
          j = (n > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, n - 1)
                                                   : $urandom_range(0, 7);
          send_item(bmm_pkg::OP_LOAD, 3'(j), $urandom, 8'($urandom));
          loads_left--;
        end else begin
          j = ready_q[$urandom_range(0, ready_q.size() - 1)];
          send_item(bmm_pkg::OP_POS, 3'($urandom), $urandom,
                    8'(($urandom << (j + 1)) | (1 << j)));
        end
        sent++;
      end
      if ($urandom_range(0, 7) == 0) begin
        send_item(bmm_pkg::OP_POS, 3'($urandom), $urandom, 8'($urandom));
        sent++;
      end
      send_item(bmm_pkg::OP_FINISH, 3'($urandom), $urandom, 8'($urandom));
      sent++;
    end
    wait_idle();
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.op          = '0;
    in_ch.queue_index = '0;
    in_ch.load_value  = '0;
    in_ch.mask_bits   = '0;
    masks_cfg         = bmm_pkg::MASKS_RESET;
    for (int k = 0; k < bmm_pkg::MAX_MASKS; k++) begin
      loaded_cnt[k]   = 0;
      consumed_cnt[k] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_mask_count();
    test_queue_full();
    test_backpressure();
    test_random();

    repeat (10) @(posedge clk);
    error_count += merge_results_due.size();
    if (error_count == 0)
      $display("boolean_mask_merge_core verification clean");
    else
      $display("boolean_mask_merge_core verification failed");
    $finish;
  end

endmodule
